[hdl/fixed_point_alu_unit_macros.svh]
// Assertion macros used by the bound property checker in hdl/fxalu_checker.sv.
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while the stop condition holds.
`define FXALU_ASSERT_SAME(lbl, clk, stop, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (stop) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the stop condition holds.
`define FXALU_ASSERT_NEXT(lbl, clk, stop, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (stop) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fxalu_pkg.sv]
package fxalu_pkg;

    typedef logic [3:0] t_opcode;
    typedef logic [1:0] t_status;

    // Operation codes.
    localparam t_opcode OP_ADD      = 4'd0;
    localparam t_opcode OP_SUB      = 4'd1;
    localparam t_opcode OP_MUL      = 4'd2;
    localparam t_opcode OP_DIV      = 4'd3;
    localparam t_opcode OP_LT       = 4'd4;
    localparam t_opcode OP_GT       = 4'd5;
    localparam t_opcode OP_LE       = 4'd6;
    localparam t_opcode OP_GE       = 4'd7;
    localparam t_opcode OP_EQ       = 4'd8;
    localparam t_opcode OP_NE       = 4'd9;
    localparam t_opcode OP_MIN      = 4'd10;
    localparam t_opcode OP_MAX      = 4'd11;
    localparam t_opcode OP_INC      = 4'd12;
    localparam t_opcode OP_DEC      = 4'd13;
    localparam t_opcode OP_TO_INT   = 4'd14;
    localparam t_opcode OP_FROM_INT = 4'd15;

    // Status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DIV_ZERO = 2'd1;
    localparam t_status ST_SAT      = 2'd2;

endpackage

[hdl/fixed_point_alu_unit.sv]
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: operand_a[31:0], operand_b[63:32]; tuser: opcode[3:0]
// m_axis    out  tdata: result_raw[31:0]; tuser: compare_true[0], status[2:1]
//
// Every request passes the input register, stage 1, the divider stages, the quotient rounding
// register and the output register, in Q24.8 by default; the restoring divider makes four quotient bits per stage.
// One request is taken per cycle unless the output stalls; all opcodes share the same pipeline, so order is kept.
// Reset (i_rst_n low at a clock edge) clears all valid bits; payload is not reset.
// A stalled output freezes the whole pipeline, and o_s_axis_tready falls with it.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS  = 8,
    parameter int WORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [63:0]            i_s_axis_tdata,  // operand_a, operand_b
    input  fxalu_pkg::t_opcode     i_s_axis_tuser,  // opcode
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,  // result_raw
    output logic [2:0]             o_m_axis_tuser   // compare_true, status
);
    import fxalu_pkg::*;

    localparam int OW  = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
    localparam int VW  = 64;
    localparam int NW  = 32 + FRAC_BITS;
    localparam int SPS = 4;
    localparam int ND  = (NW + SPS - 1) / SPS;
    localparam int QW  = ND * SPS;
    localparam int RSH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic signed [VW-1:0] RND_POS = (FRAC_BITS > 0) ? (64'sd1 <<< RSH) : 64'sd0;
    localparam logic signed [VW-1:0] RND_NEG = (FRAC_BITS > 0) ? RND_POS - 64'sd1 : 64'sd0;
    localparam int SSH = (WORD_WIDTH < 64) ? WORD_WIDTH - 1 : 62;
    localparam logic signed [VW-1:0] SAT_HI = (64'sd1 <<< SSH) - 64'sd1;
    localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef struct packed {
        logic                  valid;
        t_opcode               op;
        logic signed [31:0]    a;
        logic signed [VW-1:0]  v;
        logic signed [VW-1:0]  p;
        logic                  cmp;
        logic                  dz;
        logic                  neg;
        logic [31:0]           den;
        logic [32:0]           rem;
        logic [QW-1:0]         q;
        logic [QW-1:0]         num;
    } t_pipe;

    // Four restoring division steps.
    function automatic t_pipe f_div_step(input t_pipe s);
        t_pipe      o;
        logic [32:0] rt;
        o = s;
        for (int j = 0; j < SPS; j++) begin
            rt = {o.rem[31:0], o.num[QW-1]};
            o.num = o.num << 1;
            if (rt >= {1'b0, o.den}) begin
                o.rem = rt - {1'b0, o.den};
                o.q   = {o.q[QW-2:0], 1'b1};
            end else begin
                o.rem = rt;
                o.q   = {o.q[QW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    logic w_en;

    logic                r_s0_valid;
    t_opcode             r_s0_op;
    logic signed [31:0]  r_s0_a;
    logic signed [31:0]  r_s0_b;

    t_pipe r_s1, n_s1;
    t_pipe r_dv [ND];
    t_pipe n_dv [ND];
    t_pipe r_rq, n_rq;

    logic                r_out_valid;
    logic [31:0]         r_out_data;
    logic [2:0]          r_out_user;
    logic [31:0]         n_out_data;
    logic [2:0]          n_out_user;

    // The whole pipeline moves when the output register can take a result.
    assign w_en            = ~r_out_valid | i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Input register; operands are reduced to the word width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_s0_op <= i_s_axis_tuser;
            r_s0_a  <= 32'($signed(i_s_axis_tdata[OW-1:0]));
            r_s0_b  <= 32'($signed(i_s_axis_tdata[32+OW-1:32]));
        end
    end

    // Stage 1: simple operations, compares, product and divider setup.
    always_comb begin
        logic signed [VW-1:0] a64;
        logic signed [VW-1:0] b64;
        logic [31:0]          amag;
        a64  = VW'(r_s0_a);
        b64  = VW'(r_s0_b);
        amag = r_s0_a[31] ? 32'(-r_s0_a) : 32'(r_s0_a);
        n_s1       = '0;
        n_s1.valid = r_s0_valid;
        n_s1.op    = r_s0_op;
        n_s1.a     = r_s0_a;
        n_s1.p     = a64 * b64;
        n_s1.dz    = (r_s0_b == 32'sd0);
        n_s1.neg   = r_s0_a[31] ^ r_s0_b[31];
        n_s1.den   = r_s0_b[31] ? 32'(-r_s0_b) : 32'(r_s0_b);
        n_s1.num   = QW'(NW'(amag) << FRAC_BITS);
        case (r_s0_op)
            OP_ADD:      n_s1.v = a64 + b64;
            OP_SUB:      n_s1.v = a64 - b64;
            OP_INC:      n_s1.v = a64 + 64'sd1;
            OP_DEC:      n_s1.v = a64 - 64'sd1;
            OP_MIN:      n_s1.v = (a64 < b64) ? a64 : b64;
            OP_MAX:      n_s1.v = (a64 > b64) ? a64 : b64;
            OP_TO_INT:   n_s1.v = a64 >>> FRAC_BITS;
            OP_FROM_INT: n_s1.v = a64 <<< FRAC_BITS;
            default:     n_s1.v = '0;
        endcase
        case (r_s0_op)
            OP_LT:   n_s1.cmp = (r_s0_a <  r_s0_b);
            OP_GT:   n_s1.cmp = (r_s0_a >  r_s0_b);
            OP_LE:   n_s1.cmp = (r_s0_a <= r_s0_b);
            OP_GE:   n_s1.cmp = (r_s0_a >= r_s0_b);
            OP_EQ:   n_s1.cmp = (r_s0_a == r_s0_b);
            OP_NE:   n_s1.cmp = (r_s0_a != r_s0_b);
            default: n_s1.cmp = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s1.valid <= n_s1.valid;
        end
        if (w_en) begin
            r_s1[$bits(t_pipe)-2:0] <= n_s1[$bits(t_pipe)-2:0];
        end
    end

    // Divider stages; the first one also rounds the product.
    for (genvar k = 0; k < ND; k++) begin : g_div
        always_comb begin
            t_pipe s;
            s = (k == 0) ? r_s1 : r_dv[(k == 0) ? 0 : k - 1];
            n_dv[k] = f_div_step(s);
            if (k == 0 && s.op == OP_MUL) begin
                n_dv[k].v = (s.p + (s.p[VW-1] ? RND_NEG : RND_POS)) >>> FRAC_BITS;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k].valid <= 1'b0;
            end else if (w_en) begin
                r_dv[k].valid <= n_dv[k].valid;
            end
            if (w_en) begin
                r_dv[k][$bits(t_pipe)-2:0] <= n_dv[k][$bits(t_pipe)-2:0];
            end
        end
    end

    // Quotient rounding, half away from zero, then the sign.
    always_comb begin
        logic [QW-1:0] qr;
        n_rq = r_dv[ND-1];
        qr   = r_dv[ND-1].q
             + QW'({r_dv[ND-1].rem, 1'b0} >= {2'b00, r_dv[ND-1].den});
        if (r_dv[ND-1].op == OP_DIV) begin
            n_rq.v = r_dv[ND-1].neg ? -VW'(qr) : VW'(qr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq.valid <= 1'b0;
        end else if (w_en) begin
            r_rq.valid <= n_rq.valid;
        end
        if (w_en) begin
            r_rq[$bits(t_pipe)-2:0] <= n_rq[$bits(t_pipe)-2:0];
        end
    end

    // Output stage: saturation, division by zero and status.
    always_comb begin
        logic signed [VW-1:0] vs;
        t_status              st;
        vs = r_rq.v;
        st = ST_OK;
        if (r_rq.op == OP_DIV && r_rq.dz) begin
            vs = VW'(r_rq.a);
            st = ST_DIV_ZERO;
        end else if (WORD_WIDTH < 64 && r_rq.v > SAT_HI) begin
            vs = SAT_HI;
            st = ST_SAT;
        end else if (WORD_WIDTH < 64 && r_rq.v < SAT_LO) begin
            vs = SAT_LO;
            st = ST_SAT;
        end
        n_out_data = vs[31:0];
        n_out_user = {st, r_rq.cmp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_rq.valid;
        end
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

[hdl/fxalu_checker.sv]
`include "fixed_point_alu_unit_macros.svh"

module fxalu_unit_props (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_s_axis_tready,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [31:0]         o_m_axis_tdata,
    input logic [2:0]          o_m_axis_tuser
);
    import fxalu_pkg::*;

    // A held result keeps its payload.
    `FXALU_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed while stalled")

    // No result appears right after reset.
    `FXALU_ASSERT_NEXT(a_rst, i_clk, 1'b0, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

    // An empty output register never blocks new requests.
    `FXALU_ASSERT_SAME(a_ready, i_clk, !i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input blocked with empty output")

    // A true compare carries a zero result and ok status.
    `FXALU_ASSERT_SAME(a_cmp, i_clk, !i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tuser[2:1] == ST_OK && o_m_axis_tdata == 32'd0, "compare result not clean")

    // Status code three is never produced.
    `FXALU_ASSERT_SAME(a_status, i_clk, !i_rst_n, o_m_axis_tvalid, o_m_axis_tuser[2:1] == ST_OK || o_m_axis_tuser[2:1] == ST_DIV_ZERO || o_m_axis_tuser[2:1] == ST_SAT, "unknown status code")

endmodule

bind fixed_point_alu_unit fxalu_unit_props u_fxalu_unit_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[tb/fxalu_checker.sv]
module fxalu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [63:0] i_s_data,
    input  logic [3:0]  i_s_user,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [31:0] i_m_data,
    input  logic [2:0]  i_m_user,
    output int          o_fail_count,
    output int          o_pending
);
    import fxalu_pkg::*;

    localparam int FRAC = 8;

    typedef struct packed {
        logic [31:0] raw;
        logic        cmp;
        t_status     status;
    } alu_answer_t;

    alu_answer_t answers_due[$];

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic alu_answer_t compute_answer(input t_opcode op,
                                                   input logic [31:0] ra,
                                                   input logic [31:0] rb);
        logic signed [63:0] a, b, r, p;
        logic [63:0] m, num, den;
        logic ovf;
        alu_answer_t ans;
        a = {{32{ra[31]}}, ra};
        b = {{32{rb[31]}}, rb};
        r = '0;
        ovf = 1'b0;
        ans = '0;
        ans.status = ST_OK;
        case (op)
            OP_ADD: r = clamp32(a + b, ovf);
            OP_SUB: r = clamp32(a - b, ovf);
            OP_MUL: begin
                p = a * b;
                m = p < 0 ? -p : p;
                m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
                r = clamp32(p < 0 ? -$signed(m) : $signed(m), ovf);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r = a;
                    ans.status = ST_DIV_ZERO;
                end else begin
                    num = (a < 0 ? -a : a) << FRAC;
                    den = b < 0 ? -b : b;
                    m = (2 * num + den) / (2 * den);
                    r = clamp32(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m), ovf);
                end
            end
            OP_LT: ans.cmp = a < b;
            OP_GT: ans.cmp = a > b;
            OP_LE: ans.cmp = a <= b;
            OP_GE: ans.cmp = a >= b;
            OP_EQ: ans.cmp = a == b;
            OP_NE: ans.cmp = a != b;
            OP_MIN: r = a < b ? a : b;
            OP_MAX: r = a > b ? a : b;
            OP_INC: r = clamp32(a + 1, ovf);
            OP_DEC: r = clamp32(a - 1, ovf);
            OP_TO_INT: r = a >>> FRAC;
            default: r = clamp32(a <<< FRAC, ovf);
        endcase
        if (ovf) ans.status = ST_SAT;
        ans.raw = r[31:0];
        return ans;
    endfunction

    assign o_pending = answers_due.size();

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        alu_answer_t want;
        if (!i_rst_n) begin
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_valid && i_s_ready)
                answers_due.push_back(compute_answer(i_s_user, i_s_data[31:0],
                                                     i_s_data[63:32]));
            if (i_m_valid && i_m_ready) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result %h", i_m_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want.raw !== i_m_data || want.cmp !== i_m_user[0] ||
                        want.status !== i_m_user[2:1]) begin
                        if (want.raw !== i_m_data)
                            $error("result_raw: expected %h actual %h", want.raw, i_m_data);
                        if (want.cmp !== i_m_user[0])
                            $error("compare_true: expected %b actual %b", want.cmp,
                                   i_m_user[0]);
                        if (want.status !== i_m_user[2:1])
                            $error("status: expected %0d actual %0d", want.status,
                                   i_m_user[2:1]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb_top.sv]
module tb_top;
    import fxalu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data = '0;
    t_opcode     s_user = OP_ADD;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic [2:0]  m_user;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    always #5 i_clk = ~i_clk;

    fixed_point_alu_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user)
    );

    fxalu_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Cycle limit guards against a hung pipeline.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result-side stall in random bursts, or a long hold-off on request.
    initial begin
        int burst;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) - 4;
            3: return {{16{1'b0}}, 16'($urandom)};
            4: return {{16{1'b1}}, 16'($urandom)};
            5: return $urandom_range(0, 2047) - 1024;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and wait until it is taken; optional idle burst first.
    task automatic send_request(input t_opcode op, input logic [31:0] a,
                                input logic [31:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {b, a};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] edge_vals [6];
        int k;
        edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h100};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every opcode at the operand extremes, plus division by zero.
        for (int op = 0; op < 16; op++)
            send_request(t_opcode'(op), edge_vals[op % 6], edge_vals[(op + 1) % 6]);
        send_request(OP_DIV, 32'h1234, 32'h0);
        send_request(OP_DIV, 32'h80000000, 32'hffffffff);
        send_request(OP_MUL, 32'h80000000, 32'h80000000);
        send_request(OP_FROM_INT, 32'h80000000, 32'h0);
        send_request(OP_TO_INT, 32'hffffff01, 32'h0);
        send_request(OP_INC, 32'h7fffffff, 32'h0);
        send_request(OP_DEC, 32'h80000000, 32'h0);
        send_request(OP_MUL, 32'h00000180, 32'hffffff01);

        // Long result-side hold-off while requests keep coming, so input stalls.
        hold_off = 1'b1;
        for (k = 0; k < 40; k++)
            send_request(t_opcode'($urandom_range(0, 15)), pick_operand(), pick_operand());

        // Random traffic.
        for (k = 0; k < 1360; k++) begin
            if (k == 600) begin
                // Sender drains the pipeline completely before going on.
                s_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if (k == 1200) calm = 1'b1;
            send_request(t_opcode'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
